[design/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared codes, control bundle and index helpers for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int NUM_EL = 9;

	// matrix_order register codes
	localparam logic [1:0] ORDER_2 = 2'd2;
	localparam logic [1:0] ORDER_3 = 2'd3;

	// status field codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SINGULAR = 2'd1;
	localparam logic [1:0] STAT_SAT      = 2'd2;

	// divider lane control, shared by all lanes
	typedef struct packed {
		logic load;
		logic step;
		logic fin;
	} lane_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_DONE = 4'b1000
	} seq_state_t;

	// output element k = (i,j) takes the cofactor of element (j,i)
	function automatic int cof_src(input int k);
		return (k % 3) * 3 + (k / 3);
	endfunction

	// output elements that carry data when the 2x2 order is active
	function automatic logic used_o2(input int k);
		return (k == 0) || (k == 1) || (k == 3) || (k == 4);
	endfunction

endpackage

[design/mi3_front.sv]
// ----------------------------------------------------------------------------
// mi3_front
// Elastic seven-stage pipeline: minors, cofactors, determinant, magnitudes.
// ----------------------------------------------------------------------------
module mi3_front #(
	parameter int DATA_WIDTH = 32,
	localparam int W  = DATA_WIDTH,
	localparam int CW = 2 * DATA_WIDTH + 1,
	localparam int DW = 3 * DATA_WIDTH + 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mi3_pkg::NUM_EL*W-1:0]       in_data,
	input  logic                               in_o2,
	output logic                               out_valid,
	input  logic                               out_take,
	output logic [CW-1:0]                      cmag [mi3_pkg::NUM_EL],
	output logic [mi3_pkg::NUM_EL-1:0]         cneg,
	output logic [DW-1:0]                      dmag,
	output logic                               dneg,
	output logic                               dzero,
	output logic                               o2
);
	import mi3_pkg::*;

	localparam int PW  = 2 * W;
	localparam int PRW = 3 * W + 1;

	logic [6:0] vld_q;
	logic [6:0] en;

	logic signed [W-1:0]   e_s1 [NUM_EL];
	logic signed [W-1:0]   e_s2 [NUM_EL];
	logic signed [PW-1:0]  pa_s2 [NUM_EL];
	logic signed [PW-1:0]  pb_s2 [NUM_EL];
	logic signed [CW-1:0]  cof_s3 [NUM_EL];
	logic signed [W-1:0]   e0_s3 [3];
	logic signed [PW:0]    pl_s4 [3];
	logic signed [PW:0]    ph_s4 [3];
	logic signed [CW-1:0]  cof_s4 [NUM_EL];
	logic signed [PRW-1:0] pr_s5 [3];
	logic signed [CW-1:0]  cof_s5 [NUM_EL];
	logic signed [DW-1:0]  det_s6;
	logic signed [CW-1:0]  cof_s6 [NUM_EL];
	logic [CW-1:0]         cmag_s7 [NUM_EL];
	logic [NUM_EL-1:0]     cneg_s7;
	logic [DW-1:0]         dmag_s7;
	logic                  dneg_s7, dzero_s7;
	logic                  o2_s1, o2_s2, o2_s3, o2_s4, o2_s5, o2_s6, o2_s7;

	always_comb begin
		en[6] = !vld_q[6] || out_take;
		for (int k = 5; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < 7; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: capture elements
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < NUM_EL; k++) e_s1[k] <= $signed(in_data[k*W +: W]);
			o2_s1 <= in_o2;
		end
	end

	// stages 2 and 3: minor products, then signed cofactors
	for (genvar r = 0; r < 3; r++) begin : g_r
		for (genvar c = 0; c < 3; c++) begin : g_c
			localparam int R0  = (r == 0) ? 1 : 0;
			localparam int R1  = (r == 2) ? 1 : 2;
			localparam int C0  = (c == 0) ? 1 : 0;
			localparam int C1  = (c == 2) ? 1 : 2;
			localparam int IDX = r * 3 + c;
			localparam bit ODD = ((r + c) % 2) == 1;

			logic signed [CW-1:0] m, c3, c2;

			always_ff @(posedge clk) begin
				if (en[1]) begin
					pa_s2[IDX] <= e_s1[R0*3+C0] * e_s1[R1*3+C1];
					pb_s2[IDX] <= e_s1[R0*3+C1] * e_s1[R1*3+C0];
				end
			end

			always_comb begin
				m  = CW'(pa_s2[IDX]) - CW'(pb_s2[IDX]);
				c3 = ODD ? -m : m;
				if (IDX == 0)      c2 = CW'(e_s2[4]);
				else if (IDX == 1) c2 = -CW'(e_s2[3]);
				else if (IDX == 3) c2 = -CW'(e_s2[1]);
				else if (IDX == 4) c2 = CW'(e_s2[0]);
				else               c2 = '0;
			end

			always_ff @(posedge clk) begin
				if (en[2]) cof_s3[IDX] <= o2_s2 ? c2 : c3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			e_s2  <= e_s1;
			o2_s2 <= o2_s1;
		end
		if (en[2]) begin
			for (int j = 0; j < 3; j++) e0_s3[j] <= e_s2[j];
			o2_s3 <= o2_s2;
		end
	end

	// stage 4: first-row partial products, cofactor split into low and high halves
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 3; j++) begin
				pl_s4[j] <= e0_s3[j] * $signed({1'b0, cof_s3[j][W-1:0]});
				ph_s4[j] <= e0_s3[j] * $signed(cof_s3[j][CW-1:W]);
			end
			cof_s4 <= cof_s3;
			o2_s4  <= o2_s3;
		end
	end

	// stage 5: recombine halves
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int j = 0; j < 3; j++) begin
				pr_s5[j] <= (PRW'(ph_s4[j]) <<< W) + PRW'(pl_s4[j]);
			end
			cof_s5 <= cof_s4;
			o2_s5  <= o2_s4;
		end
	end

	// stage 6: determinant
	always_ff @(posedge clk) begin
		if (en[5]) begin
			det_s6 <= DW'(pr_s5[0]) + DW'(pr_s5[1]) + DW'(pr_s5[2]);
			cof_s6 <= cof_s5;
			o2_s6  <= o2_s5;
		end
	end

	// stage 7: magnitudes and signs, cofactors routed transposed to lanes
	always_ff @(posedge clk) begin
		if (en[6]) begin
			dneg_s7  <= det_s6[DW-1];
			dmag_s7  <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
			dzero_s7 <= (det_s6 == '0);
			for (int k = 0; k < NUM_EL; k++) begin
				cneg_s7[k] <= cof_s6[cof_src(k)][CW-1];
				cmag_s7[k] <= cof_s6[cof_src(k)][CW-1] ? CW'(-cof_s6[cof_src(k)])
				                                        : CW'(cof_s6[cof_src(k)]);
			end
			o2_s7 <= o2_s6;
		end
	end

	assign cmag  = cmag_s7;
	assign cneg  = cneg_s7;
	assign dmag  = dmag_s7;
	assign dneg  = dneg_s7;
	assign dzero = dzero_s7;
	assign o2    = o2_s7;

endmodule

[design/mi3_div_lane.sv]
// ----------------------------------------------------------------------------
// mi3_div_lane
// Restoring divider lane: one quotient bit per cycle, rounded at the end.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	localparam int CW = 2 * DATA_WIDTH + 1,
	localparam int DM = 3 * DATA_WIDTH + 3,
	localparam int QB = DATA_WIDTH + 1
) (
	input  logic                clk,
	input  mi3_pkg::lane_ctl_t  ctl,
	input  logic [CW-1:0]       cmag,
	input  logic                cneg,
	input  logic [DM-1:0]       dmag,
	input  logic                dneg,
	output logic [QB:0]         qr,
	output logic                neg,
	output logic                ovf
);
	import mi3_pkg::*;

	localparam int NW   = CW + 2 * FRAC_BITS;
	localparam int NHW  = NW - QB;
	localparam int CMPW = ((NHW > DM) ? NHW : DM) + 1;

	logic [NW-1:0]   num;
	logic [CMPW-1:0] nhi_x, d_x;
	logic [DM:0]     trial, diff;
	logic            ge, rnd;

	logic [DM-1:0] rem_q;
	logic [QB-1:0] nlo_q, q_q;
	logic [QB:0]   qr_q;
	logic          neg_q, ovf_q;

	always_comb begin
		num   = {cmag, {(2*FRAC_BITS){1'b0}}};
		nhi_x = CMPW'(num[NW-1:QB]);
		d_x   = CMPW'(dmag);
		trial = {rem_q, nlo_q[QB-1]};
		diff  = trial - {1'b0, dmag};
		ge    = trial >= {1'b0, dmag};
		rnd   = {rem_q, 1'b0} >= {1'b0, dmag};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			// quotient too large for QB bits: saturates regardless
			ovf_q <= nhi_x >= d_x;
			rem_q <= nhi_x[DM-1:0];
			nlo_q <= num[QB-1:0];
			q_q   <= '0;
			neg_q <= cneg ^ dneg;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[DM-1:0] : trial[DM-1:0];
			q_q   <= {q_q[QB-2:0], ge};
			nlo_q <= {nlo_q[QB-2:0], 1'b0};
		end else if (ctl.fin) begin
			qr_q <= (QB+1)'(q_q) + (QB+1)'(rnd);
		end
	end

	assign qr  = qr_q;
	assign neg = neg_q;
	assign ovf = ovf_q;

endmodule

[design/mi3_merge.sv]
// ----------------------------------------------------------------------------
// mi3_merge
// Combine lane quotients: saturate, apply sign, form status, output register.
// ----------------------------------------------------------------------------
module mi3_merge #(
	parameter int DATA_WIDTH = 32,
	localparam int W    = DATA_WIDTH,
	localparam int QB   = DATA_WIDTH + 1,
	localparam int OUTW = ((9 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_take,
	input  logic [QB:0]                 qr [mi3_pkg::NUM_EL],
	input  logic [mi3_pkg::NUM_EL-1:0]  neg,
	input  logic [mi3_pkg::NUM_EL-1:0]  ovf,
	input  logic                        sing,
	input  logic                        o2,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUTW-1:0]             m_tdata
);
	import mi3_pkg::*;

	localparam logic [QB:0] LIM_POS = {3'b000, {(W-1){1'b1}}};
	localparam logic [QB:0] LIM_NEG = {3'b001, {(W-1){1'b0}}};

	logic              take;
	logic [QB:0]       lim [NUM_EL];
	logic [QB:0]       val [NUM_EL];
	logic [QB:0]       res [NUM_EL];
	logic [NUM_EL-1:0] sat, act;
	logic [1:0]        status;
	logic [OUTW-1:0]   packed_d;

	logic              tvalid_q;
	logic [OUTW-1:0]   tdata_q;

	assign take    = !tvalid_q || m_tready;
	assign in_take = take;

	always_comb begin
		packed_d = '0;
		for (int k = 0; k < NUM_EL; k++) begin
			act[k] = !o2 || used_o2(k);
			lim[k] = neg[k] ? LIM_NEG : LIM_POS;
			sat[k] = act[k] && (ovf[k] || (qr[k] > lim[k]));
			val[k] = sat[k] ? lim[k] : qr[k];
			res[k] = neg[k] ? (~val[k] + 1'b1) : val[k];
			if (act[k] && !sing) packed_d[k*W +: W] = res[k][W-1:0];
		end
		if (sing)      status = STAT_SINGULAR;
		else if (|sat) status = STAT_SAT;
		else           status = STAT_OK;
		packed_d[NUM_EL*W +: 2] = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (take) begin
			tvalid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) tdata_q <= packed_d;
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

[design/matrix_inverse_3x3.sv]
// Path: 7 front stages, 1 load, DATA_WIDTH+1 divide steps, a rounding step,
//   then 1 output register from input to output.
// Dividers: bit-serial, one item at a time; they load the next item only when the
//   merge takes the last; the front pipeline takes the next item meanwhile.
// Reset: arst_n clears all valid bits and the sequencer, matrix_order returns to 3.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 2x2 or 3x3 fixed-point matrix by adjugate and cofactors.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
	// inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22, status
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((9*DATA_WIDTH+2+7)/8)*8-1:0]     m_axis_tdata,
	input  logic                                    cfg_wr_en,
	input  logic [1:0]                              cfg_wr_data
);
	import mi3_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int CW   = 2 * W + 1;
	localparam int DM   = 3 * W + 3;
	localparam int QB   = W + 1;
	localparam int CNTW = $clog2(QB);
	localparam logic [CNTW-1:0] LAST_STEP = CNTW'(QB - 1);

	// Matrix order register; codes other than 2 run the 3x3 path.
	logic [1:0] matrix_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) matrix_order_q <= ORDER_3;
		else if (cfg_wr_en) matrix_order_q <= cfg_wr_data;
	end

	// Front pipeline: minors, cofactors and determinant, all exact.
	logic [CW-1:0]     f_cmag [NUM_EL];
	logic [NUM_EL-1:0] f_cneg;
	logic [DM-1:0]     f_dmag;
	logic              f_dneg, f_dzero, f_o2, f_valid;

	lane_ctl_t ctl;

	mi3_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[NUM_EL*W-1:0]),
		.in_o2     (matrix_order_q == ORDER_2),
		.out_valid (f_valid),
		.out_take  (ctl.load),
		.cmag      (f_cmag),
		.cneg      (f_cneg),
		.dmag      (f_dmag),
		.dneg      (f_dneg),
		.dzero     (f_dzero),
		.o2        (f_o2)
	);

	// Per-item values shared by all lanes, held for the whole division.
	logic [DM-1:0] dmag_q;
	logic          sing_q, o2_q;
	logic [DM-1:0] lane_d;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dmag_q <= f_dmag;
			sing_q <= f_dzero;
			o2_q   <= f_o2;
		end
	end

	// The load cycle compares against the fresh determinant; steps use the held copy.
	assign lane_d = ctl.load ? f_dmag : dmag_q;

	// Sequencer: load, QB divide steps, round, then hold until the merge takes it.
	seq_state_t      st_q, st_d;
	logic [CNTW-1:0] cnt_q;
	logic            m_take;

	always_comb begin
		ctl  = '0;
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (f_valid) begin
					ctl.load = 1'b1;
					st_d     = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				if (cnt_q == LAST_STEP) st_d = ST_FIN;
			end
			ST_FIN: begin
				ctl.fin = 1'b1;
				st_d    = ST_DONE;
			end
			ST_DONE: begin
				// hand off and start the next item in the same cycle
				if (m_take) begin
					if (f_valid) begin
						ctl.load = 1'b1;
						st_d     = ST_RUN;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (ctl.load) cnt_q <= '0;
			else if (ctl.step) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Nine divider lanes, one per output element, in lockstep.
	logic [QB:0]       l_qr [NUM_EL];
	logic [NUM_EL-1:0] l_neg, l_ovf;

	for (genvar k = 0; k < NUM_EL; k++) begin : g_lane
		mi3_div_lane #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.cmag (f_cmag[k]),
			.cneg (f_cneg[k]),
			.dmag (lane_d),
			.dneg (f_dneg),
			.qr   (l_qr[k]),
			.neg  (l_neg[k]),
			.ovf  (l_ovf[k])
		);
	end

	// Merge: saturate, sign, status, and the output register.
	mi3_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (st_q == ST_DONE),
		.in_take  (m_take),
		.qr       (l_qr),
		.neg      (l_neg),
		.ovf      (l_ovf),
		.sing     (sing_q),
		.o2       (o2_q),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

endmodule

[design/mi3_checker.sv]
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the matrix inverse output stream.
// ----------------------------------------------------------------------------
module mi3_checker #(
	parameter int DATA_WIDTH = 32,
	localparam int W    = DATA_WIDTH,
	localparam int OUTW = ((9 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input logic            clk,
	input logic            arst_n,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [OUTW-1:0] m_axis_tdata,
	input logic            cfg_wr_en,
	input logic [1:0]      cfg_wr_data
);
	import mi3_pkg::*;

	logic       o2_q;
	logic [1:0] status;

	assign status = m_axis_tdata[9*W +: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o2_q <= 1'b0;
		else if (cfg_wr_en) o2_q <= (cfg_wr_data == ORDER_2);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> status != 2'd3)
		else $error("undefined status code");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STAT_SINGULAR |-> m_axis_tdata[9*W-1:0] == '0)
		else $error("singular item with nonzero elements");

	a_order2: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o2_q |-> m_axis_tdata[2*W +: W] == '0
			&& m_axis_tdata[5*W +: 4*W] == '0)
		else $error("unused elements nonzero in 2x2 order");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_wr_data   (cfg_wr_data)
);
